>>> rtl/core/nat_pkg.sv
// Package: shared types and codes for the neighbor aging table.
package nat_pkg;

    localparam int ADDR_W  = 48;
    localparam int LIMIT_W = 16;

    localparam logic FUNC_HEARD = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    typedef enum logic [1:0] {
        EV_HEARD = 2'd0,
        EV_LOST  = 2'd1,
        EV_FULL  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic              func;
        logic [ADDR_W-1:0] station_addr;
    } t_in;

    typedef struct packed {
        logic [1:0]        event_kind;
        logic [ADDR_W-1:0] neighbor_addr;
        logic              last;
    } t_out;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [LIMIT_W-1:0] count;
    } t_entry;

endpackage

>>> rtl/core/neighbor_aging_table_unit.sv
// Top level: neighbor address table with per-entry countdown, memory based.
//
//  channel   direction  handshake                       payload
//  item      in         start && !busy                  i_item   (nat_pkg::t_in)
//  result    out        o_valid, one cycle, no stall    o_result (nat_pkg::t_out)
//  config    in         i_cfg_we                        i_cfg_wdata (beacons_lost_limit)
//
// Every item holds busy high for one sweep: one slot of the single entry memory
// is read per cycle; each read is checked the cycle after and written back if
// its count is decremented or its address matches. A lost report is held until
// the next loss is found, so its last flag is known; the final result shows in
// the cycle busy drops. The receiver cannot stall, so results are never held
// back by the output side. Synchronous active-low reset empties the table (valid
// flops) and sets the limit to 1; memory contents are undefined until written.
module neighbor_aging_table_unit #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  nat_pkg::t_in                   i_item,
    output logic                           o_valid,
    output nat_pkg::t_out                  o_result,
    input  logic                           i_cfg_we,
    input  logic [nat_pkg::LIMIT_W-1:0]    i_cfg_wdata
);
    import nat_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    t_entry mem [TABLE_DEPTH];

    t_state             r_state, n_state;
    logic [TABLE_DEPTH-1:0] r_valid, n_valid;
    logic [LIMIT_W-1:0] r_limit;
    t_in                r_item, n_item;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic               r_eval_vld, n_eval_vld;
    logic [IDX_W-1:0]   r_eval_idx, n_eval_idx;
    logic               r_found, n_found;
    logic               r_free_vld, n_free_vld;
    logic [IDX_W-1:0]   r_free_idx, n_free_idx;
    logic               r_pend, n_pend;
    logic [ADDR_W-1:0]  r_pend_addr, n_pend_addr;
    logic               r_out_vld, n_out_vld;
    t_out               r_out, n_out;
    t_entry             r_rd_data;

    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    t_entry             wr_data;
    logic               eval_last;

    assign eval_last = r_eval_vld && (r_eval_idx == LAST_IDX);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (start) n_state = ST_SCAN;
            ST_SCAN:   if (eval_last) n_state = ST_FINISH;
            ST_FINISH: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_valid     = r_valid;
        n_item      = r_item;
        n_idx       = r_idx;
        n_eval_vld  = 1'b0;
        n_eval_idx  = r_eval_idx;
        n_found     = r_found;
        n_free_vld  = r_free_vld;
        n_free_idx  = r_free_idx;
        n_pend      = r_pend;
        n_pend_addr = r_pend_addr;
        n_out_vld   = 1'b0;
        n_out       = r_out;
        rd_en       = 1'b0;
        rd_addr     = r_idx[IDX_W-1:0];
        wr_en       = 1'b0;
        wr_addr     = r_eval_idx;
        wr_data     = r_rd_data;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_item     = i_item;
                    n_idx      = '0;
                    n_found    = 1'b0;
                    n_free_vld = 1'b0;
                    n_pend     = 1'b0;
                end
            end
            ST_SCAN: begin
                if (r_idx != SCAN_END) begin
                    rd_en      = 1'b1;
                    n_idx      = r_idx + CNT_W'(1);
                    n_eval_vld = 1'b1;
                    n_eval_idx = r_idx[IDX_W-1:0];
                end
                if (r_eval_vld) begin
                    if (r_item.func == FUNC_TICK) begin
                        if (r_valid[r_eval_idx]) begin
                            if (r_rd_data.count != '0) begin
                                wr_en         = 1'b1;
                                wr_data.count = r_rd_data.count - LIMIT_W'(1);
                            end else begin
                                n_valid[r_eval_idx] = 1'b0;
                                // report the previous loss now that another follows
                                if (r_pend) begin
                                    n_out_vld           = 1'b1;
                                    n_out.event_kind    = EV_LOST;
                                    n_out.neighbor_addr = r_pend_addr;
                                    n_out.last          = 1'b0;
                                end
                                n_pend      = 1'b1;
                                n_pend_addr = r_rd_data.addr;
                            end
                        end
                    end else begin
                        if (r_valid[r_eval_idx]) begin
                            if (r_rd_data.addr == r_item.station_addr) begin
                                wr_en         = 1'b1;
                                wr_data.count = r_limit;
                                n_found       = 1'b1;
                            end
                        end else if (!r_free_vld) begin
                            n_free_vld = 1'b1;
                            n_free_idx = r_eval_idx;
                        end
                    end
                end
            end
            ST_FINISH: begin
                n_out.last          = 1'b1;
                n_out.neighbor_addr = r_item.station_addr;
                if (r_item.func == FUNC_TICK) begin
                    n_out_vld           = r_pend;
                    n_out.event_kind    = EV_LOST;
                    n_out.neighbor_addr = r_pend_addr;
                end else begin
                    n_out_vld = 1'b1;
                    if (r_found) begin
                        n_out.event_kind = EV_HEARD;
                    end else if (r_free_vld) begin
                        n_out.event_kind    = EV_HEARD;
                        wr_en               = 1'b1;
                        wr_addr             = r_free_idx;
                        wr_data.addr        = r_item.station_addr;
                        wr_data.count       = r_limit;
                        n_valid[r_free_idx] = 1'b1;
                    end else begin
                        n_out.event_kind = EV_FULL;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_valid    <= '0;
            r_limit    <= LIMIT_W'(1);
            r_eval_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_valid    <= n_valid;
            r_eval_vld <= n_eval_vld;
            r_out_vld  <= n_out_vld;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item      <= n_item;
        r_idx       <= n_idx;
        r_eval_idx  <= n_eval_idx;
        r_found     <= n_found;
        r_free_vld  <= n_free_vld;
        r_free_idx  <= n_free_idx;
        r_pend      <= n_pend;
        r_pend_addr <= n_pend_addr;
        r_out       <= n_out;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_valid  = r_out_vld;
    assign o_result = r_out;

endmodule

>>> rtl/core/nat_checker.sv
// Checker on the top level ports of the neighbor aging table, with its bind.
module nat_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_valid,
    input nat_pkg::t_out o_result
);
    import nat_pkg::*;

    // accepted item always starts a sweep
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    // results only come out of a sweep
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without a sweep in progress");

    // heard and full events are single results
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result.event_kind != EV_LOST) |-> o_result.last)
        else $error("heard or full event without last");

    // nothing follows the final result of an item right away
    a_quiet_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.last |=> !o_valid)
        else $error("result right after last");

endmodule

bind neighbor_aging_table_unit nat_checker u_nat_checker (.*);

>>> tb/sv/nat_event_checker.sv
// Checker: predicts neighbor table events and compares them with the result channel.
`timescale 1ns / 1ps
module nat_event_checker #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_busy,
    input  nat_pkg::t_in                i_item,
    input  logic                        i_valid,
    input  nat_pkg::t_out               i_result,
    input  logic                        i_cfg_we,
    input  logic [nat_pkg::LIMIT_W-1:0] i_cfg_wdata,
    input  logic                        i_flush,
    output int                          o_pending,
    output int                          o_errors,
    output int                          o_checked,
    output int                          o_lost,
    output int                          o_full
);
    import nat_pkg::*;

    // shadow copy of the neighbor table
    logic               nb_valid [TABLE_DEPTH];
    logic [ADDR_W-1:0]  nb_addr  [TABLE_DEPTH];
    logic [LIMIT_W-1:0] nb_count [TABLE_DEPTH];
    logic [LIMIT_W-1:0] lost_limit;

    t_out events_due [$];
    int   err_count  = 0;
    int   checked    = 0;
    int   lost_seen  = 0;
    int   full_seen  = 0;
    bit   flush_done = 1'b0;

    initial o_pending = 0;

    assign o_errors  = err_count;
    assign o_checked = checked;
    assign o_lost    = lost_seen;
    assign o_full    = full_seen;

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        err_count++;
    endtask

    function automatic void predict_beacon(input logic [ADDR_W-1:0] addr);
        int   free_slot;
        bit   found;
        t_out ev;
        free_slot = -1;
        found     = 1'b0;
        for (int slot = 0; slot < TABLE_DEPTH; slot++) begin
            if (nb_valid[slot]) begin
                if (!found && nb_addr[slot] == addr) begin
                    nb_count[slot] = lost_limit;
                    found = 1'b1;
                end
            end else if (free_slot < 0) begin
                free_slot = slot;
            end
        end
        ev.event_kind    = EV_HEARD;
        ev.neighbor_addr = addr;
        ev.last          = 1'b1;
        if (!found) begin
            if (free_slot < 0) begin
                ev.event_kind = EV_FULL;
            end else begin
                nb_valid[free_slot] = 1'b1;
                nb_addr[free_slot]  = addr;
                nb_count[free_slot] = lost_limit;
            end
        end
        events_due = {events_due, ev};
    endfunction

    // aging pass: decrement live counts, expire zero counts in slot order
    function automatic void predict_sweep();
        int   n_lost;
        t_out ev;
        n_lost = 0;
        for (int slot = 0; slot < TABLE_DEPTH; slot++) begin
            if (nb_valid[slot]) begin
                if (nb_count[slot] != '0) begin
                    nb_count[slot] = nb_count[slot] - 1'b1;
                end else begin
                    nb_valid[slot]   = 1'b0;
                    ev.event_kind    = EV_LOST;
                    ev.neighbor_addr = nb_addr[slot];
                    ev.last          = 1'b0;
                    events_due = {events_due, ev};
                    n_lost++;
                end
            end
        end
        if (n_lost > 0) begin
            events_due[events_due.size() - 1].last = 1'b1;
        end
    endfunction

    task automatic check_event(input t_out got);
        t_out want;
        if (events_due.size() == 0) begin
            report_error($sformatf("unexpected result kind=%0d addr=%h last=%b",
                                   got.event_kind, got.neighbor_addr, got.last));
        end else begin
            want = events_due.pop_front();
            if (got.event_kind !== want.event_kind)
                report_error($sformatf("event_kind %0d, want %0d (addr %h)",
                                       got.event_kind, want.event_kind, want.neighbor_addr));
            if (got.neighbor_addr !== want.neighbor_addr)
                report_error($sformatf("neighbor_addr %h, want %h",
                                       got.neighbor_addr, want.neighbor_addr));
            if (got.last !== want.last)
                report_error($sformatf("last %b, want %b (addr %h)",
                                       got.last, want.last, want.neighbor_addr));
        end
        checked++;
        if (got.event_kind == EV_LOST) lost_seen++;
        if (got.event_kind == EV_FULL) full_seen++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            events_due.delete();
            lost_limit = 16'd1;
            for (int slot = 0; slot < TABLE_DEPTH; slot++) nb_valid[slot] = 1'b0;
        end else begin
            // results retire before a new item is predicted on the same edge
            if (i_valid) check_event(i_result);
            if (i_cfg_we) lost_limit = i_cfg_wdata;
            if (i_start && !i_busy) begin
                if (i_item.func == FUNC_TICK) predict_sweep();
                else predict_beacon(i_item.station_addr);
            end
            if (i_flush && !flush_done) begin
                flush_done = 1'b1;
                if (events_due.size() != 0)
                    report_error($sformatf("%0d expected results never arrived",
                                           events_due.size()));
            end
        end
        o_pending <= events_due.size();
    end

endmodule

>>> tb/sv/tb_neighbor_aging_table_unit.sv
// Testbench top: drives beacon and tick items and limit writes, and gives the verdict.
`timescale 1ns / 1ps
module tb_neighbor_aging_table_unit;
    import nat_pkg::*;

    localparam int TABLE_DEPTH   = 32;
    localparam int POOL_SIZE     = 40;  // more stations than slots, so the table can fill
    localparam int SETTLE_CYCLES = TABLE_DEPTH + 8;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int CYCLE_LIMIT   = 200000;

    logic               i_clk;
    logic               i_rst_n   = 1'b0;
    logic               start     = 1'b0;
    logic               busy;
    t_in                item      = '0;
    logic               res_valid;
    t_out               result;
    logic               cfg_we    = 1'b0;
    logic [LIMIT_W-1:0] cfg_wdata = '0;
    logic               flush     = 1'b0;

    int pending, errors, checked, lost_events, full_events;
    int cycles      = 0;
    int n_beacons   = 0;
    int n_ticks     = 0;
    int n_settings  = 0;
    bit burst       = 1'b0;

    logic [ADDR_W-1:0] station_pool [POOL_SIZE];

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    neighbor_aging_table_unit #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (item),
        .o_valid    (res_valid),
        .o_result   (result),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    nat_event_checker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_event_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_busy     (busy),
        .i_item     (item),
        .i_valid    (res_valid),
        .i_result   (result),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_flush    (flush),
        .o_pending  (pending),
        .o_errors   (errors),
        .o_checked  (checked),
        .o_lost     (lost_events),
        .o_full     (full_events)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [ADDR_W-1:0] random_addr();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[ADDR_W-1:0];
    endfunction

    // start stays high across back-to-back items; busy rises right after acceptance
    task automatic feed(input logic f, input logic [ADDR_W-1:0] addr);
        int  gap;
        t_in nxt;
        if ($urandom_range(0, 15) == 0) burst = !burst;
        gap = burst ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        nxt.func         = f;
        nxt.station_addr = addr;
        start <= 1'b1;
        item  <= nxt;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (f == FUNC_TICK) n_ticks++;
        else n_beacons++;
    endtask

    // a tick may produce nothing, so allow a full sweep after the last result
    task automatic set_limit(input logic [LIMIT_W-1:0] value);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic sweep_pool();
        int first;
        first = $urandom_range(0, POOL_SIZE - 1);
        for (int k = 0; k < POOL_SIZE; k++)
            feed(FUNC_HEARD, station_pool[(first + k) % POOL_SIZE]);
    endtask

    task automatic run_mixed(input int count);
        int pick;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) feed(FUNC_TICK, random_addr());
            else if (pick < 45) feed(FUNC_HEARD, random_addr());
            else feed(FUNC_HEARD, station_pool[$urandom_range(0, POOL_SIZE - 1)]);
        end
    endtask

    initial begin
        int waited;
        station_pool[0] = '0;
        station_pool[1] = '1;
        station_pool[2] = 48'hAAAA_AAAA_AAAA;
        station_pool[3] = 48'h5555_5555_5555;
        for (int k = 4; k < POOL_SIZE; k++) station_pool[k] = random_addr();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset limit of 1: insert, refresh, silent decrement, double loss, empty tick
        feed(FUNC_HEARD, station_pool[0]);
        feed(FUNC_HEARD, station_pool[1]);
        feed(FUNC_HEARD, station_pool[0]);
        feed(FUNC_TICK, '0);
        feed(FUNC_TICK, '1);
        feed(FUNC_TICK, random_addr());

        // zero limit: lost on the very next tick
        set_limit('0);
        feed(FUNC_HEARD, station_pool[2]);
        feed(FUNC_TICK, '0);
        feed(FUNC_HEARD, station_pool[3]);
        feed(FUNC_HEARD, station_pool[2]);
        feed(FUNC_TICK, '0);

        // max limit: fill all slots, overflow reports table full
        set_limit('1);
        sweep_pool();
        run_mixed(10);

        // refresh everything to 1, then the first tick counts it down and the second expires the whole table
        set_limit(16'd1);
        sweep_pool();
        feed(FUNC_TICK, random_addr());
        feed(FUNC_TICK, random_addr());

        set_limit(16'd2);
        run_mixed(35);
        set_limit('0);
        run_mixed(35);
        set_limit(LIMIT_W'($urandom_range(3, 8)));
        run_mixed(35);
        set_limit(LIMIT_W'($urandom_range(1, 65535)));
        run_mixed(35);
        set_limit(16'd1);
        run_mixed(35);

        start <= 1'b0;
        @(posedge i_clk);
        waited = 0;
        while ((pending != 0 || busy) && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        flush <= 1'b1;
        repeat (2) @(posedge i_clk);

        $display("Sent %0d beacons and %0d ticks across %0d limit writes in %0d cycles.",
                 n_beacons, n_ticks, n_settings, cycles);
        $display("Compared %0d results: %0d lost, %0d table-full.",
                 checked, lost_events, full_events);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/nat_pkg.sv
rtl/core/neighbor_aging_table_unit.sv
rtl/core/nat_checker.sv
tb/sv/nat_event_checker.sv
tb/sv/tb_neighbor_aging_table_unit.sv
